// File: sv/wcmt_pkg.sv
// Shared widths, microcode types and defaults for the weighted count max tree.
package wcmt_pkg;

  localparam int TOTAL_W    = 48;
  localparam int BUCKET_W   = 10;
  localparam int WEIGHT_W   = 32;
  localparam int LEAVES_DEF = 1024;

  // Microprogram steps
  typedef enum logic [1:0] {
    STEP_CLEAR,
    STEP_WAIT,
    STEP_LEAF,
    STEP_NODE
  } step_t;

  // Datapath operation selected by a control word
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_READ_LEAF,
    OP_LEAF,
    OP_NODE
  } op_t;

  // Jump condition selected by a control word
  typedef enum logic [1:0] {
    C_CLR_LAST,
    C_ITEM,
    C_OOR,
    C_ROOT
  } cond_sel_t;

  typedef struct packed {
    op_t       op;
    logic      accept;
    cond_sel_t cond;
    step_t     jmp;
    step_t     nxt;
    logic      emit_on_jump;
  } ctl_word_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic clr_last;
    logic item;
    logic oor;
    logic root;
  } cond_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t  op;
    logic accept;
    logic emit;
  } ctl_t;

endpackage

// File: sv/wcmt_if.sv
// Valid/ready channel interfaces for update items and result items.
interface wcmt_in_if import wcmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [BUCKET_W-1:0] value_index;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, output func, output value_index, output weight,
                  input ready);
  modport sink (input valid, input func, input value_index, input weight,
                output ready);
endinterface

interface wcmt_out_if import wcmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] max_total;
  logic               overflow;

  modport source (output valid, output max_total, output overflow, input ready);
  modport sink (input valid, input max_total, input overflow, output ready);
endinterface

// File: sv/weighted_count_max_tree_core.sv
// Top level: max segment tree in one memory, walked leaf to root by microcode.
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   func, value_index, weight
//  out_chan  out  valid/ready   max_total, overflow
//
// An item reads its leaf, writes the leaf, then updates each ancestor in turn up to
// the root, as the node memory has a single read and a single write port. An
// out-of-range bucket skips the walk and reports the current root.
// After reset a clearing pass writes all 2*LEAVES nodes, one per cycle, before
// the first transaction is accepted. A result waits in a holding register while
// the output is stalled, so the next transaction can already be accepted.
module weighted_count_max_tree_core import wcmt_pkg::*; #(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wcmt_in_if.sink           in_chan,
  wcmt_out_if.source        out_chan
);

  localparam int NODES  = 2 * LEAVES;
  localparam int ADDR_W = $clog2(NODES);
  localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(LEAVES);
  localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);
  localparam logic [ADDR_W-1:0] ROOT_NODE = ADDR_W'(1);

  ctl_t  ctl;
  cond_t cond;

  logic [TOTAL_W-1:0]  mem [NODES];
  logic [TOTAL_W-1:0]  rd_r;
  logic                we;
  logic [ADDR_W-1:0]   wa, ra;
  logic [TOTAL_W-1:0]  wd;

  logic [ADDR_W-1:0]   pos_r, clr_r;
  logic [TOTAL_W-1:0]  cur_r, root_r;
  logic                func_r, flag_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [WEIGHT_W-1:0] weight_r;

  logic                pend_r, out_valid_r;
  logic [TOTAL_W-1:0]  pend_total_r, out_total_r;
  logic                pend_flag_r, out_flag_r;

  logic [TOTAL_W:0]    sum_w, diff_w;
  logic [TOTAL_W-1:0]  upd_w, max_w;
  logic                upd_flag_w, oor_w;
  logic [ADDR_W-1:0]   parent_w;
  logic                out_load, slot_free, accept;

  wcmt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  always_comb begin
    oor_w      = {{(32 - BUCKET_W){1'b0}}, bucket_r} >= 32'(LEAVES);
    sum_w      = {1'b0, rd_r} + {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, weight_r};
    diff_w     = {1'b0, rd_r} - {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, weight_r};
    upd_w      = func_r ? diff_w[TOTAL_W-1:0] : sum_w[TOTAL_W-1:0];
    upd_flag_w = func_r ? diff_w[TOTAL_W] : sum_w[TOTAL_W];
    max_w      = (rd_r > cur_r) ? rd_r : cur_r;
    parent_w   = pos_r >> 1;

    // result slot frees up this cycle if the holding register drains
    out_load  = pend_r & (~out_valid_r | out_chan.ready);
    slot_free = ~pend_r | out_load;
    accept    = ctl.accept & slot_free & in_chan.valid;

    cond.clr_last = (clr_r == LAST_NODE);
    cond.item     = accept;
    cond.oor      = oor_w;
    cond.root     = (parent_w == ROOT_NODE);

    we = 1'b0;
    wa = clr_r;
    wd = '0;
    ra = LEAF_BASE + ADDR_W'(in_chan.value_index);
    case (ctl.op)
      OP_CLEAR: begin
        we = 1'b1;
      end
      OP_LEAF: begin
        we = ~oor_w;
        wa = pos_r;
        wd = upd_w;
        ra = pos_r ^ ADDR_W'(1);
      end
      OP_NODE: begin
        we = 1'b1;
        wa = parent_w;
        wd = max_w;
        ra = parent_w ^ ADDR_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign in_chan.ready      = ctl.accept & slot_free;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.max_total = out_total_r;
  assign out_chan.overflow  = out_flag_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  // item registers and tree walk
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_chan.func;
      bucket_r <= in_chan.value_index;
      weight_r <= in_chan.weight;
      pos_r    <= LEAF_BASE + ADDR_W'(in_chan.value_index);
    end
    case (ctl.op)
      OP_LEAF: begin
        cur_r  <= upd_w;
        flag_r <= upd_flag_w & ~oor_w;
      end
      OP_NODE: begin
        cur_r <= max_w;
        pos_r <= parent_w;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      root_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (ctl.op == OP_NODE && cond.root) begin
        root_r <= max_w;
      end
      if (ctl.emit) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      // leaf step emits only for an out-of-range bucket
      pend_total_r <= (ctl.op == OP_NODE) ? max_w : root_r;
      pend_flag_r  <= (ctl.op == OP_NODE) ? flag_r : 1'b0;
    end
    if (out_load) begin
      out_total_r <= pend_total_r;
      out_flag_r  <= pend_flag_r;
    end
  end

endmodule

// File: sv/wcmt_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
module wcmt_seq import wcmt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cond_t cond,
  output ctl_t  ctl
);

  step_t     step_r, step_nxt;
  ctl_word_t cw;
  logic      taken;

  function automatic ctl_word_t rom(input step_t s);
    ctl_word_t w;
    case (s)
      STEP_CLEAR: w = '{op: OP_CLEAR,     accept: 1'b0, cond: C_CLR_LAST,
                        jmp: STEP_WAIT, nxt: STEP_CLEAR, emit_on_jump: 1'b0};
      STEP_WAIT:  w = '{op: OP_READ_LEAF, accept: 1'b1, cond: C_ITEM,
                        jmp: STEP_LEAF, nxt: STEP_WAIT,  emit_on_jump: 1'b0};
      // bucket out of range: report the current root and go back
      STEP_LEAF:  w = '{op: OP_LEAF,      accept: 1'b0, cond: C_OOR,
                        jmp: STEP_WAIT, nxt: STEP_NODE,  emit_on_jump: 1'b1};
      STEP_NODE:  w = '{op: OP_NODE,      accept: 1'b0, cond: C_ROOT,
                        jmp: STEP_WAIT, nxt: STEP_NODE,  emit_on_jump: 1'b1};
      default:    w = '{op: OP_READ_LEAF, accept: 1'b0, cond: C_ITEM,
                        jmp: STEP_WAIT, nxt: STEP_WAIT,  emit_on_jump: 1'b0};
    endcase
    return w;
  endfunction

  always_comb begin
    cw = rom(step_r);
    case (cw.cond)
      C_CLR_LAST: taken = cond.clr_last;
      C_ITEM:     taken = cond.item;
      C_OOR:      taken = cond.oor;
      C_ROOT:     taken = cond.root;
      default:    taken = 1'b0;
    endcase
    step_nxt   = taken ? cw.jmp : cw.nxt;
    ctl.op     = cw.op;
    ctl.accept = cw.accept;
    ctl.emit   = cw.emit_on_jump & taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: sim/wcmt_tb_pkg.sv
// Update operation codes shared by the stimulus and the result monitor.
package wcmt_tb_pkg;

  typedef enum logic {
    FUNC_ADD,
    FUNC_REMOVE
  } update_op_t;

endpackage

// File: sim/max_tree_monitor.sv
// Watches both channels, tracks the bucket tree and checks every result.
module max_tree_monitor import wcmt_pkg::*; import wcmt_tb_pkg::*; #(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wcmt_in_if          in_mon,
  wcmt_out_if         out_mon,
  output int unsigned outstanding,
  output int unsigned mismatches
);

  typedef struct packed {
    logic [TOTAL_W-1:0] max_total;
    logic               overflow;
  } peak_t;

  // node 1 is the root, node k has children 2k and 2k+1, bucket b at LEAVES + b
  logic [TOTAL_W-1:0] node_total [2*LEAVES];
  peak_t              expected_peaks [$];

  function automatic peak_t apply_update(update_op_t op, logic [BUCKET_W-1:0] bucket,
                                         logic [WEIGHT_W-1:0] weight);
    int                 pos;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] leaf;
    logic [TOTAL_W-1:0] amount;
    peak_t              res;
    res.overflow = 1'b0;
    amount = {{(TOTAL_W - WEIGHT_W){1'b0}}, weight};
    if (int'(bucket) < LEAVES) begin
      pos = LEAVES + int'(bucket);
      leaf = node_total[pos];
      if (op == FUNC_ADD) begin
        sum = {1'b0, leaf} + {1'b0, amount};
        res.overflow = sum[TOTAL_W];
        leaf = sum[TOTAL_W-1:0];
      end else begin
        res.overflow = amount > leaf;
        leaf = leaf - amount;
      end
      node_total[pos] = leaf;
      for (pos = pos >> 1; pos != 0; pos = pos >> 1)
        node_total[pos] = (node_total[2*pos] > node_total[2*pos+1]) ?
                          node_total[2*pos] : node_total[2*pos+1];
    end
    res.max_total = node_total[1];
    return res;
  endfunction

  always @(posedge clk) begin
    peak_t       seen;
    peak_t       want;
    int unsigned bad;
    bad = 0;
    if (!rst_n) begin
      foreach (node_total[i]) node_total[i] = '0;
      expected_peaks.delete();
      outstanding <= 0;
      mismatches <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_peaks.push_back(apply_update(update_op_t'(in_mon.func), in_mon.value_index,
                                              in_mon.weight));
      if (out_mon.valid && out_mon.ready) begin
        seen.max_total = out_mon.max_total;
        seen.overflow = out_mon.overflow;
        if (expected_peaks.size() == 0) begin
          bad = 1;
          if (mismatches < 10)
            $display("[%0t] result with nothing expected: max_total=%h overflow=%b",
                     $realtime, seen.max_total, seen.overflow);
        end else begin
          want = expected_peaks.pop_front();
          if (seen.max_total !== want.max_total || seen.overflow !== want.overflow) begin
            bad = 1;
            if (mismatches < 10)
              $display("[%0t] mismatch: max_total exp %h got %h, overflow exp %b got %b",
                       $realtime, want.max_total, seen.max_total, want.overflow,
                       seen.overflow);
          end
        end
      end
      outstanding <= expected_peaks.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, update stimulus, output stalls and the verdict.
module tb_top;
  import wcmt_pkg::*;
  import wcmt_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  logic [BUCKET_W-1:0] hot_buckets [8];

  wcmt_in_if  in_chan ();
  wcmt_out_if out_chan ();

  weighted_count_max_tree_core #(.LEAVES(LEAVES_DEF)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  max_tree_monitor #(.LEAVES(LEAVES_DEF)) u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Returns at the edge where the transaction is accepted.
  task automatic send_update(input update_op_t op, input logic [BUCKET_W-1:0] bucket,
                             input logic [WEIGHT_W-1:0] amount);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func <= op;
    in_chan.value_index <= bucket;
    in_chan.weight <= amount;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    update_op_t          op;
    logic [BUCKET_W-1:0] bucket;
    logic [WEIGHT_W-1:0] amount;
    in_chan.valid = 1'b0;
    in_chan.func = 1'b0;
    in_chan.value_index = '0;
    in_chan.weight = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ties, wrap and underflow
    send_update(FUNC_ADD,    10'd0,    32'hFFFF_FFFF);
    send_update(FUNC_ADD,    10'd1023, 32'hFFFF_FFFF);
    send_update(FUNC_ADD,    10'd1023, 32'd1);
    send_update(FUNC_REMOVE, 10'd512,  32'd1);          // borrow from empty bucket
    send_update(FUNC_ADD,    10'd512,  32'd1);          // wraps back to zero
    send_update(FUNC_REMOVE, 10'd1023, 32'hFFFF_FFFF);
    send_update(FUNC_REMOVE, 10'd0,    32'hFFFF_FFFF);  // exact, no borrow
    send_update(FUNC_ADD,    10'd0,    32'd0);
    send_update(FUNC_REMOVE, 10'd0,    32'd0);
    send_update(FUNC_REMOVE, 10'd0,    32'd1);
    send_update(FUNC_REMOVE, 10'd0,    32'hFFFF_FFFF);
    send_update(FUNC_ADD,    10'd0,    32'hFFFF_FFFF);
    send_update(FUNC_ADD,    10'd0,    32'd2);          // carry out of 48 bits
    send_update(FUNC_ADD,    10'd341,  32'h2AAA_AAAA);
    send_update(FUNC_ADD,    10'd682,  32'h5555_5555);
    send_update(FUNC_REMOVE, 10'd341,  32'h2AAA_AAAB);
    send_update(FUNC_ADD,    10'd2,    32'd7);
    send_update(FUNC_ADD,    10'd3,    32'd7);          // sibling tie
    send_update(FUNC_REMOVE, 10'd682,  32'h5555_5555);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
      endcase
      foreach (hot_buckets[i]) hot_buckets[i] = BUCKET_W'($urandom);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // most updates land on a few buckets so totals build up and the max moves
        if ($urandom_range(0, 99) < 70)
          bucket = hot_buckets[$urandom_range(0, 7)];
        else
          bucket = BUCKET_W'($urandom);
        op = ($urandom_range(0, 99) < 65) ? FUNC_ADD : FUNC_REMOVE;
        case ($urandom_range(0, 9))
          0:       amount = '0;
          1:       amount = '1;
          2, 3, 4: amount = WEIGHT_W'($urandom_range(0, 255));
          5, 6:    amount = WEIGHT_W'($urandom_range(0, 65535));
          default: amount = $urandom;
        endcase
        send_update(op, bucket, amount);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
